// ----- rtl/core/dba_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// disk block allocator. No dependencies.

package dba_pkg;

	localparam int unsigned DISK_BLOCKS = 128;
	localparam int unsigned MAX_FILES   = 32;

	localparam int unsigned BLK_W    = $clog2(DISK_BLOCKS);
	localparam int unsigned CNT_W    = BLK_W + 1;
	localparam int unsigned ID_W     = $clog2(MAX_FILES);
	localparam int unsigned OWN_W    = $clog2(MAX_FILES + 1);
	localparam int unsigned BYTES_W  = 24;
	localparam int unsigned BB_W     = 17;
	localparam int unsigned BIU_W    = 8;
	localparam int unsigned TAG_W    = 8;
	localparam int unsigned TOTAL_W  = 8;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned STEP_W   = $clog2(BYTES_W);
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = BB_W'(4096);
	localparam logic [BIU_W-1:0] BLOCKS_IN_USE_RST = BIU_W'(128);
	localparam logic [TAG_W-1:0] TAG_RST           = TAG_W'(65);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_BLOCK_BYTES   = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_EXISTS  = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_NOFILE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_EXISTS  = 3'd0,
		RES_NOSPACE = 3'd1,
		RES_NOFILE  = 3'd2,
		RES_ALLOC   = 3'd3,
		RES_FREE    = 3'd4
	} res_kind_t;

	typedef enum logic [1:0] {
		SCAN_COUNT   = 2'd0,
		SCAN_TAKE    = 2'd1,
		SCAN_RELEASE = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic       load_req;
		logic       div_start;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       load_result;
		res_kind_t  res_kind;
	} dba_cmd_t;

	typedef struct packed {
		logic op_free;
		logic present;
		logic zero_bytes;
		logic scan_busy;
		logic div_done;
		logic no_room;
		logic out_free;
	} dba_stat_t;

endpackage

// ----- rtl/core/disk_block_allocator.sv -----
// Top level of the disk block allocator: configuration registers, request
// sequencer and datapath. Depends on dba_pkg, dba_regs, dba_ctrl, dba_datapath.
//
//   Port group | Direction | Role
//   -----------+-----------+-------------------------------------------------
//   s_axis_*   | in        | Requests: op in tuser, file id and byte count
//   m_axis_*   | out       | Results: status in tuser, block and tag data
//   APB        | in/out    | block_bytes at 0x0, blocks_in_use at 0x4
//
// A request is taken in an idle cycle and checked in the next one. An allocate
// then counts free blocks in one pass over the owner memory (span reads, where
// span is blocks_in_use capped at 128) while the 24-step divider rounds the
// size up to blocks; both must finish before the decide state. A decide state,
// a take pass over the same span and a result state follow. A free makes one
// pass over all 128 blocks before its result is registered. A request refused
// at the check goes straight to the result state. The sequencer returns to
// idle after each result before the next transfer can be taken. Each pass
// reads the owner memory one block per cycle.
// Reset empties the disk at once through per-block valid bits, clears all
// files, sets the next tag to 'A' and loads the register defaults.
// The result sits in an output register, so the next request is accepted
// while a result still waits; a new result waits only if that register is
// still full.

module disk_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // file_id[4:0], byte_count[28:5]
	input  logic [0:0]                  s_axis_tuser,  // op[0]

	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [23:0]                 m_axis_tdata,  // first_block[6:0], block_total[14:7],
	                                                   // file_tag[22:15]
	output logic [1:0]                  m_axis_tuser,  // status[1:0]

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dba_pkg::APB_AW-1:0]  paddr,
	input  logic [dba_pkg::APB_DW-1:0]  pwdata,
	output logic [dba_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	dba_pkg::dba_cmd_t              cmd;
	dba_pkg::dba_stat_t             stat;
	logic [dba_pkg::BB_W-1:0]       block_bytes;
	logic [dba_pkg::BIU_W-1:0]      blocks_in_use;
	logic [dba_pkg::STAT_W-1:0]     res_status;
	logic [dba_pkg::BLK_W-1:0]      res_first;
	logic [dba_pkg::TOTAL_W-1:0]    res_total;
	logic [dba_pkg::TAG_W-1:0]      res_tag;

	dba_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.block_bytes   (block_bytes),
		.blocks_in_use (blocks_in_use)
	);

	// The sequencer takes a new request only when it has nothing in flight.
	dba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dba_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_op           (s_axis_tuser[0]),
		.in_file_id      (s_axis_tdata[4:0]),
		.in_byte_count   (s_axis_tdata[28:5]),
		.block_bytes     (block_bytes),
		.blocks_in_use   (blocks_in_use),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_status      (res_status),
		.out_first_block (res_first),
		.out_block_total (res_total),
		.out_file_tag    (res_tag)
	);

	// Result packing, lowest field first, padded to whole bytes.
	assign m_axis_tdata = {1'b0, res_tag, res_total, res_first};
	assign m_axis_tuser = res_status;

endmodule

// ----- rtl/core/dba_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on dba_pkg.

module dba_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dba_pkg::APB_AW-1:0]  paddr,
	input  logic [dba_pkg::APB_DW-1:0]  pwdata,
	output logic [dba_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [dba_pkg::BB_W-1:0]    block_bytes,
	output logic [dba_pkg::BIU_W-1:0]   blocks_in_use
);

	logic [dba_pkg::BB_W-1:0]  block_bytes_q;
	logic [dba_pkg::BIU_W-1:0] blocks_in_use_q;
	logic                      wr_en;
	logic                      reg_sel;

	// Registers sit on word boundaries, so bit 2 picks the register.
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q   <= dba_pkg::BLOCK_BYTES_RST;
			blocks_in_use_q <= dba_pkg::BLOCKS_IN_USE_RST;
		end else if (wr_en) begin
			if (reg_sel == dba_pkg::REG_BLOCK_BYTES) begin
				block_bytes_q <= pwdata[dba_pkg::BB_W-1:0];
			end else begin
				blocks_in_use_q <= pwdata[dba_pkg::BIU_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == dba_pkg::REG_BLOCK_BYTES) begin
			prdata = dba_pkg::APB_DW'(block_bytes_q);
		end else begin
			prdata = dba_pkg::APB_DW'(blocks_in_use_q);
		end
	end

	assign block_bytes   = block_bytes_q;
	assign blocks_in_use = blocks_in_use_q;

endmodule

// ----- rtl/core/dba_div.sv -----
// Restoring divider, one quotient bit per cycle, giving the rounded-up
// quotient of a byte count by the block size. Depends on dba_pkg.

module dba_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dba_pkg::BYTES_W-1:0]   dividend,
	input  logic [dba_pkg::BB_W-1:0]      divisor,
	output logic                          done,
	output logic [dba_pkg::BYTES_W-1:0]   quot_ceil
);

	logic                          busy_q;
	logic                          done_q;
	logic [dba_pkg::STEP_W-1:0]    step_q;
	logic [dba_pkg::BB_W-1:0]      div_q;
	logic [dba_pkg::BB_W-1:0]      rem_q;
	logic [dba_pkg::BYTES_W-1:0]   quo_q;
	logic [dba_pkg::BB_W:0]        trial;
	logic [dba_pkg::BB_W:0]        diff;
	logic                          ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[dba_pkg::BYTES_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + dba_pkg::STEP_W'(1);
			if (step_q == dba_pkg::STEP_W'(dba_pkg::BYTES_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[dba_pkg::BB_W-1:0] : trial[dba_pkg::BB_W-1:0];
			quo_q <= {quo_q[dba_pkg::BYTES_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quot_ceil = quo_q + dba_pkg::BYTES_W'(rem_q != '0);

endmodule

// ----- rtl/core/dba_datapath.sv -----
// Datapath: request registers, block owner memory with its scan pipeline,
// file presence bits, display tag counter and the result register.
// Depends on dba_pkg and dba_div.

module dba_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dba_pkg::dba_cmd_t             cmd,
	output dba_pkg::dba_stat_t            stat,
	input  logic                          in_op,
	input  logic [dba_pkg::ID_W-1:0]      in_file_id,
	input  logic [dba_pkg::BYTES_W-1:0]   in_byte_count,
	input  logic [dba_pkg::BB_W-1:0]      block_bytes,
	input  logic [dba_pkg::BIU_W-1:0]     blocks_in_use,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [dba_pkg::STAT_W-1:0]    out_status,
	output logic [dba_pkg::BLK_W-1:0]     out_first_block,
	output logic [dba_pkg::TOTAL_W-1:0]   out_block_total,
	output logic [dba_pkg::TAG_W-1:0]     out_file_tag
);

	// Request registers.
	logic                          op_q;
	logic [dba_pkg::ID_W-1:0]      id_q;
	logic [dba_pkg::BYTES_W-1:0]   bytes_q;

	// Persistent state.
	logic [dba_pkg::MAX_FILES-1:0]   present_q;
	logic [dba_pkg::TAG_W-1:0]       next_tag_q;
	logic [dba_pkg::DISK_BLOCKS-1:0] owner_vld_q;
	logic [dba_pkg::OWN_W-1:0]       owner_mem [dba_pkg::DISK_BLOCKS];

	// Scan engine.
	logic                          busy_q;
	dba_pkg::scan_mode_t           mode_q;
	logic [dba_pkg::CNT_W-1:0]     idx_q;
	logic [dba_pkg::CNT_W-1:0]     limit_q;
	logic                          rd_vld_s1;
	logic [dba_pkg::BLK_W-1:0]     rd_addr_s1;
	logic [dba_pkg::OWN_W-1:0]     mem_rd_s1;
	logic                          vld_rd_s1;
	logic [dba_pkg::CNT_W-1:0]     freec_q;
	logic [dba_pkg::CNT_W-1:0]     left_q;
	logic [dba_pkg::CNT_W-1:0]     cnt_q;
	logic                          got_q;
	logic [dba_pkg::BLK_W-1:0]     first_q;

	// Result register.
	logic                          out_valid_q;
	dba_pkg::status_t              out_status_q;
	logic [dba_pkg::BLK_W-1:0]     out_first_q;
	logic [dba_pkg::TOTAL_W-1:0]   out_total_q;
	logic [dba_pkg::TAG_W-1:0]     out_tag_q;

	logic [dba_pkg::BB_W-1:0]      bb_eff;
	logic [dba_pkg::CNT_W-1:0]     span;
	logic                          div_done;
	logic [dba_pkg::BYTES_W-1:0]   need;
	logic                          issue;
	logic [dba_pkg::OWN_W-1:0]     owner_s1;
	logic [dba_pkg::OWN_W-1:0]     own_code;
	logic                          is_free;
	logic                          take;
	logic                          rel;

	assign bb_eff   = (block_bytes == '0) ? dba_pkg::BB_W'(1) : block_bytes;
	assign span     = (dba_pkg::CNT_W'(blocks_in_use) > dba_pkg::CNT_W'(dba_pkg::DISK_BLOCKS))
		? dba_pkg::CNT_W'(dba_pkg::DISK_BLOCKS) : dba_pkg::CNT_W'(blocks_in_use);
	assign own_code = dba_pkg::OWN_W'(id_q) + dba_pkg::OWN_W'(1);

	dba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (bytes_q),
		.divisor   (bb_eff),
		.done      (div_done),
		.quot_ceil (need)
	);

	// A block whose valid bit is clear reads as free.
	assign owner_s1 = vld_rd_s1 ? mem_rd_s1 : '0;
	assign is_free  = owner_s1 == '0;
	assign issue    = busy_q && (idx_q < limit_q);
	assign take     = rd_vld_s1 && (mode_q == dba_pkg::SCAN_TAKE) && is_free && (left_q != '0);
	assign rel      = rd_vld_s1 && (mode_q == dba_pkg::SCAN_RELEASE) && (owner_s1 == own_code);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q    <= in_op;
			id_q    <= in_file_id;
			bytes_q <= in_byte_count;
		end
	end

	// Owner memory: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		if (issue) begin
			mem_rd_s1 <= owner_mem[idx_q[dba_pkg::BLK_W-1:0]];
			vld_rd_s1 <= owner_vld_q[idx_q[dba_pkg::BLK_W-1:0]];
		end
		rd_addr_s1 <= idx_q[dba_pkg::BLK_W-1:0];
		if (take) begin
			owner_mem[rd_addr_s1] <= own_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_vld_q <= '0;
			busy_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.scan_start) begin
				busy_q <= 1'b1;
			end else if (!issue && !rd_vld_s1) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				owner_vld_q[rd_addr_s1] <= 1'b1;
			end else if (rel) begin
				owner_vld_q[rd_addr_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			mode_q  <= cmd.scan_mode;
			idx_q   <= '0;
			limit_q <= (cmd.scan_mode == dba_pkg::SCAN_RELEASE)
				? dba_pkg::CNT_W'(dba_pkg::DISK_BLOCKS) : span;
			freec_q <= '0;
			cnt_q   <= '0;
			got_q   <= 1'b0;
			first_q <= '0;
			left_q  <= need[dba_pkg::CNT_W-1:0];
		end else begin
			if (issue) begin
				idx_q <= idx_q + dba_pkg::CNT_W'(1);
			end
			if (rd_vld_s1 && (mode_q == dba_pkg::SCAN_COUNT) && is_free) begin
				freec_q <= freec_q + dba_pkg::CNT_W'(1);
			end
			if (take) begin
				left_q <= left_q - dba_pkg::CNT_W'(1);
			end
			if (rel) begin
				cnt_q <= cnt_q + dba_pkg::CNT_W'(1);
			end
			if ((take || rel) && !got_q) begin
				got_q   <= 1'b1;
				first_q <= rd_addr_s1;
			end
		end
	end

	// Presence bits, tag counter and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			next_tag_q  <= dba_pkg::TAG_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load_result && (cmd.res_kind == dba_pkg::RES_ALLOC)) begin
				present_q[id_q] <= 1'b1;
				next_tag_q      <= next_tag_q + dba_pkg::TAG_W'(1);
			end else if (cmd.load_result && (cmd.res_kind == dba_pkg::RES_FREE)) begin
				present_q[id_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_first_q <= '0;
			out_total_q <= '0;
			out_tag_q   <= '0;
			case (cmd.res_kind)
				dba_pkg::RES_EXISTS: begin
					out_status_q <= dba_pkg::ST_EXISTS;
				end
				dba_pkg::RES_NOFILE: begin
					out_status_q <= dba_pkg::ST_NOFILE;
				end
				dba_pkg::RES_ALLOC: begin
					out_status_q <= dba_pkg::ST_OK;
					out_first_q  <= first_q;
					out_total_q  <= need[dba_pkg::TOTAL_W-1:0];
					out_tag_q    <= next_tag_q;
				end
				dba_pkg::RES_FREE: begin
					out_status_q <= dba_pkg::ST_OK;
					out_first_q  <= first_q;
					out_total_q  <= dba_pkg::TOTAL_W'(cnt_q);
				end
				default: begin
					out_status_q <= dba_pkg::ST_NOSPACE;
				end
			endcase
		end
	end

	assign stat.op_free    = op_q == dba_pkg::OP_FREE;
	assign stat.present    = present_q[id_q];
	assign stat.zero_bytes = bytes_q == '0;
	assign stat.scan_busy  = busy_q;
	assign stat.div_done   = div_done;
	assign stat.no_room    = need > dba_pkg::BYTES_W'(freec_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_first_block = out_first_q;
	assign out_block_total = out_total_q;
	assign out_file_tag    = out_tag_q;

endmodule

// ----- rtl/core/dba_ctrl.sv -----
// Request sequencer: checks, count and divide, take or release scan, result.
// Depends on dba_pkg.

module dba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dba_pkg::dba_stat_t  stat,
	output dba_pkg::dba_cmd_t   cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_CHECK   = 7'b0000010,
		S_COUNT   = 7'b0000100,
		S_DECIDE  = 7'b0001000,
		S_TAKE    = 7'b0010000,
		S_RELEASE = 7'b0100000,
		S_RESULT  = 7'b1000000
	} state_t;

	state_t                state_q;
	state_t                state_d;
	dba_pkg::res_kind_t    res_q;
	dba_pkg::res_kind_t    res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= dba_pkg::RES_NOSPACE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		res_d           = res_q;
		in_ready        = 1'b0;
		cmd.load_req    = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.scan_start  = 1'b0;
		cmd.scan_mode   = dba_pkg::SCAN_COUNT;
		cmd.load_result = 1'b0;
		cmd.res_kind    = res_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.op_free) begin
					if (stat.present) begin
						res_d   = dba_pkg::RES_EXISTS;
						state_d = S_RESULT;
					end else if (stat.zero_bytes) begin
						res_d   = dba_pkg::RES_NOSPACE;
						state_d = S_RESULT;
					end else begin
						cmd.div_start  = 1'b1;
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = dba_pkg::SCAN_COUNT;
						state_d        = S_COUNT;
					end
				end else if (!stat.present) begin
					res_d   = dba_pkg::RES_NOFILE;
					state_d = S_RESULT;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = dba_pkg::SCAN_RELEASE;
					state_d        = S_RELEASE;
				end
			end
			S_COUNT: begin
				if (!stat.scan_busy && stat.div_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.no_room) begin
					res_d   = dba_pkg::RES_NOSPACE;
					state_d = S_RESULT;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = dba_pkg::SCAN_TAKE;
					state_d        = S_TAKE;
				end
			end
			S_TAKE: begin
				if (!stat.scan_busy) begin
					res_d   = dba_pkg::RES_ALLOC;
					state_d = S_RESULT;
				end
			end
			S_RELEASE: begin
				if (!stat.scan_busy) begin
					res_d   = dba_pkg::RES_FREE;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
